// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on every clock edge, disabled during reset
`define ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Implication with the consequent checked in the next cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/pmsp_pkg.sv =====
package pmsp_pkg;

	// Framing and field characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Magnitude saturation point, 2^31
	localparam logic [31:0] MAG_SAT = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	// Default maximum frame length
	localparam int FRAME_LEN_DEF = 64;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_M     = 2'd1;
	localparam logic [1:0] STAT_NO_COMMA = 2'd2;
	localparam logic [1:0] STAT_BAD_NUM  = 2'd3;

	// Number parse phases, one-hot
	typedef enum logic [7:0] {
		PH_LEAD = 8'b0000_0001,
		PH_WS   = 8'b0000_0010,
		PH_SIGN = 8'b0000_0100,
		PH_INT  = 8'b0000_1000,
		PH_DOT  = 8'b0001_0000,
		PH_FRAC = 8'b0010_0000,
		PH_DONE = 8'b0100_0000,
		PH_FAIL = 8'b1000_0000
	} phase_t;

	// Running state of the numeric field
	typedef struct packed {
		phase_t      phase;
		logic        neg;
		logic [31:0] accum;
		logic [1:0]  frac;
	} num_t;

	localparam num_t NUM_CLEAR = '{phase: PH_LEAD, neg: 1'b0, accum: 32'd0, frac: 2'd0};

	// One result item
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] milli;
		logic               ok;
	} res_t;

	localparam int RES_W = $bits(res_t);

	// Scale that turns the kept digits into milli-units
	function automatic logic [9:0] frac_scale(input logic [1:0] frac);
		logic [9:0] s;
		unique case (frac)
			2'd0: s = 10'd1000;
			2'd1: s = 10'd100;
			2'd2: s = 10'd10;
			2'd3: s = 10'd1;
		endcase
		return s;
	endfunction

endpackage

// ===== src/power_meter_sentence_parser_top.sv =====
// Power meter sentence parser. Takes one UART byte per transfer and gives one result per
// complete frame ('$' ... CR LF): the decimal field between the last comma before the
// first 'm' and that 'm', in milli-units, with a status code. A byte is registered in the
// input register and parsed from there; a result is registered in the output register
// when its LF is parsed. One byte per cycle is sustained while no result is stuck, set by the
// combinational parse step (accumulate times ten plus digit) between input and output
// registers. While a result waits in the output register and is not taken, the input
// register keeps any byte it holds and, once full, accepts no further transfer until it goes out.
`include "assert_macros.svh"

module power_meter_sentence_parser_top
	import pmsp_pkg::*;
#(
	parameter int FRAME_LEN = FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [0] value_ok, [32:1] power_milli, [34:33] status_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       en;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	res_t       out_res_q;

	// Parse proceeds unless a result is stuck in the output register
	assign advance  = !(out_valid_q && !m_tready);
	assign s_tready = advance || !valid_s1;
	assign en       = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	pmsp_parser #(
		.FRAME_LEN (FRAME_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.c         (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(40 - RES_W)'(0), out_res_q};

	// Checks
	`ASSERT_NEXT(a_hold_s1, m_tvalid && !m_tready && valid_s1, valid_s1 && $stable(byte_s1), "input stage moved while output stalled")
	`ASSERT_IMPL(a_ready_low, !s_tready, valid_s1 && m_tvalid && !m_tready, "input stalled without a waiting result")
	`ASSERT_IMPL(a_res_on_lf, res_valid, en && byte_s1 == CH_LF, "result produced without a processed LF")

endmodule

// ===== src/pmsp_num_step.sv =====
module pmsp_num_step
	import pmsp_pkg::*;
(
	input  num_t       cur,
	input  logic [7:0] c,
	output num_t       nxt
);

	logic        digit;
	logic        space;
	logic        white;
	logic [35:0] acc_mul;
	logic [31:0] acc_add;
	phase_t      ph;

	assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign space = (c == CH_SP);
	assign white = space || ((c >= CH_TAB) && (c <= CH_CR));

	// accum * 10 + digit, saturated at 2^31
	assign acc_mul = ({4'd0, cur.accum} << 3) + ({4'd0, cur.accum} << 1) + {32'd0, c[3:0]};
	assign acc_add = (acc_mul > {4'd0, MAG_SAT}) ? MAG_SAT : acc_mul[31:0];

	// leading spaces are skipped; anything else starts the white space phase
	assign ph = (cur.phase == PH_LEAD) ? PH_WS : cur.phase;

	always_comb begin
		nxt = cur;
		if (!(cur.phase == PH_LEAD && space)) begin
			nxt.phase = ph;
			unique case (ph)
				PH_WS: begin
					if (white) begin
						nxt.phase = PH_WS;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						nxt.neg   = (c == CH_MINUS);
						nxt.phase = PH_SIGN;
					end else if (digit) begin
						nxt.accum = acc_add;
						nxt.phase = PH_INT;
					end else if (c == CH_DOT) begin
						nxt.phase = PH_DOT;
					end else begin
						nxt.phase = PH_FAIL;
					end
				end
				PH_SIGN: begin
					if (digit) begin
						nxt.accum = acc_add;
						nxt.phase = PH_INT;
					end else if (c == CH_DOT) begin
						nxt.phase = PH_DOT;
					end else begin
						nxt.phase = PH_FAIL;
					end
				end
				PH_INT: begin
					if (digit) begin
						nxt.accum = acc_add;
					end else if (c == CH_DOT) begin
						nxt.phase = PH_FRAC;
					end else begin
						nxt.phase = PH_DONE;
					end
				end
				PH_DOT, PH_FRAC: begin
					if (digit) begin
						// digits past the third are dropped
						if (cur.frac != 2'd3) begin
							nxt.accum = acc_add;
							nxt.frac  = cur.frac + 2'd1;
						end
						nxt.phase = PH_FRAC;
					end else begin
						nxt.phase = (ph == PH_DOT) ? PH_FAIL : PH_DONE;
					end
				end
				default: begin
					// done or failed: rest of field ignored
				end
			endcase
		end
	end

endmodule

// ===== src/pmsp_result.sv =====
module pmsp_result
	import pmsp_pkg::*;
(
	input  num_t num,
	input  logic m_seen,
	input  logic comma_seen,
	output res_t res
);

	logic [41:0] mag;
	logic [31:0] mag_sat;
	logic [31:0] mag_pos;
	logic        num_ok;

	// Scale to milli-units and saturate the magnitude
	assign mag     = {10'd0, num.accum} * {32'd0, frac_scale(num.frac)};
	assign mag_sat = (mag > {10'd0, MAG_SAT}) ? MAG_SAT : mag[31:0];
	assign mag_pos = (mag_sat > POS_MAX) ? POS_MAX : mag_sat;
	assign num_ok  = (num.phase == PH_INT) || (num.phase == PH_FRAC) ||
	                 (num.phase == PH_DONE);

	always_comb begin
		res.ok     = 1'b0;
		res.milli  = 32'sd0;
		res.status = STAT_BAD_NUM;
		priority if (!m_seen) begin
			res.status = STAT_NO_M;
		end else if (!comma_seen) begin
			res.status = STAT_NO_COMMA;
		end else if (num_ok) begin
			res.ok     = 1'b1;
			res.status = STAT_OK;
			res.milli  = num.neg ? $signed(32'd0 - mag_sat) : $signed(mag_pos);
		end else begin
			res.status = STAT_BAD_NUM;
		end
	end

endmodule

// ===== src/pmsp_parser.sv =====
module pmsp_parser
	import pmsp_pkg::*;
#(
	parameter int FRAME_LEN = FRAME_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] c,
	output logic       res_valid,
	output res_t       res
);

	localparam int CNT_W = $clog2(FRAME_LEN);

	logic [CNT_W-1:0] count_q;
	logic             cr_q;
	logic             ended_q;
	logic             m_q;
	logic             comma_q;
	num_t             num_q;
	num_t             num_fed;
	logic             idle;
	logic             last_slot;

	pmsp_num_step u_num_step (
		.cur (num_q),
		.c   (c),
		.nxt (num_fed)
	);

	pmsp_result u_result (
		.num        (num_q),
		.m_seen     (m_q),
		.comma_seen (comma_q),
		.res        (res)
	);

	assign idle      = (count_q == '0);
	assign last_slot = (count_q == CNT_W'(FRAME_LEN - 1));
	assign res_valid = en && !idle && cr_q && (c == CH_LF);

	// Framing and field tracking, one byte per cycle while en is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cr_q    <= 1'b0;
			ended_q <= 1'b0;
			m_q     <= 1'b0;
			comma_q <= 1'b0;
			num_q   <= NUM_CLEAR;
		end else if (en) begin
			if (idle) begin
				if (c == CH_START) begin
					count_q <= CNT_W'(1);
					cr_q    <= 1'b0;
					ended_q <= 1'b0;
					m_q     <= 1'b0;
					comma_q <= 1'b0;
					num_q   <= NUM_CLEAR;
				end
			end else if (cr_q || last_slot) begin
				// frame complete, dropped, or too long: back to idle (a CR in the last slot is still taken)
				count_q <= '0;
				cr_q    <= 1'b0;
				ended_q <= 1'b0;
				m_q     <= 1'b0;
				comma_q <= 1'b0;
				num_q   <= NUM_CLEAR;
				if (!cr_q && c == CH_CR) begin
					count_q <= count_q;
					cr_q    <= 1'b1;
					ended_q <= ended_q;
					m_q     <= m_q;
					comma_q <= comma_q;
					num_q   <= num_q;
				end
			end else if (c == CH_CR) begin
				cr_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
				if (!ended_q && !m_q) begin
					priority if (c == CH_NUL) begin
						ended_q <= 1'b1;
					end else if (c == CH_M) begin
						m_q <= 1'b1;
					end else if (c == CH_COMMA) begin
						comma_q <= 1'b1;
						num_q   <= NUM_CLEAR;
					end else if (comma_q) begin
						num_q <= num_fed;
					end else begin
						// text before the first comma is not parsed
						num_q <= num_q;
					end
				end
			end
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench
	import pmsp_pkg::*;
;

	localparam int FRAME_LEN       = FRAME_LEN_DEF;
	localparam int ITEMS_PER_PHASE = 270;
	localparam int HOLD_CYCLES     = 400;
	localparam int N_ROWS          = 26;

	// One row of the directed table: a byte and, on an LF, an optional typed result
	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		res_t       want;
	} dir_row_t;

	localparam res_t NO_RES = '0;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	power_meter_sentence_parser_top #(
		.FRAME_LEN(FRAME_LEN)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// Directed table: idle bytes, the three non-ok status codes, a signed fraction,
	// a frame broken after CR whose '$' must not restart
	dir_row_t directed_rows [0:N_ROWS-1] = '{
		'{8'hFF,    1'b0, NO_RES},
		'{CH_NUL,   1'b0, NO_RES},
		'{CH_START, 1'b0, NO_RES},
		'{CH_M,     1'b0, NO_RES},
		'{CH_CR,    1'b0, NO_RES},
		'{CH_LF,    1'b1, '{STAT_NO_COMMA, 32'sd0, 1'b0}},
		'{CH_START, 1'b0, NO_RES},
		'{CH_COMMA, 1'b0, NO_RES},
		'{CH_M,     1'b0, NO_RES},
		'{CH_CR,    1'b0, NO_RES},
		'{CH_LF,    1'b1, '{STAT_BAD_NUM, 32'sd0, 1'b0}},
		'{CH_START, 1'b0, NO_RES},
		'{CH_COMMA, 1'b0, NO_RES},
		'{CH_MINUS, 1'b0, NO_RES},
		'{8'h31,    1'b0, NO_RES},
		'{CH_DOT,   1'b0, NO_RES},
		'{8'h35,    1'b0, NO_RES},
		'{CH_M,     1'b0, NO_RES},
		'{CH_CR,    1'b0, NO_RES},
		'{CH_LF,    1'b1, '{STAT_OK, -32'sd1500, 1'b1}},
		'{CH_START, 1'b0, NO_RES},
		'{CH_CR,    1'b0, NO_RES},
		'{CH_START, 1'b0, NO_RES},
		'{CH_START, 1'b0, NO_RES},
		'{CH_CR,    1'b0, NO_RES},
		'{CH_LF,    1'b1, '{STAT_NO_M, 32'sd0, 1'b0}}
	};

	// Predicted parser state
	int          frame_bytes;
	bit          cr_pending;
	bit          text_done;
	bit          m_found;
	bit          comma_found;
	phase_t      num_phase;
	bit          num_neg;
	logic [31:0] num_mag;
	logic [1:0]  frac_kept;

	res_t        expected_readings [$];
	logic [7:0]  frame_buf [$];

	int idle_mode;
	int hold_req;
	int error_count;
	int bytes_sent;
	int results_checked;

	function automatic int send_idle_pct();
		return (idle_mode == 0) ? 29 : (idle_mode == 1) ? 53 : 0;
	endfunction

	function automatic int recv_idle_pct();
		return (idle_mode == 0) ? 53 : (idle_mode == 1) ? 29 : 0;
	endfunction

	function automatic void clear_field();
		num_phase = PH_LEAD;
		num_neg   = 1'b0;
		num_mag   = '0;
		frac_kept = '0;
	endfunction

	function automatic void clear_frame();
		frame_bytes = 0;
		cr_pending  = 1'b0;
		text_done   = 1'b0;
		m_found     = 1'b0;
		comma_found = 1'b0;
		clear_field();
	endfunction

	// Accumulate one decimal digit, saturating at 2^31
	function automatic void push_digit(input logic [7:0] d);
		logic [35:0] t;
		t = 36'(num_mag) * 36'd10 + 36'(d);
		if (t > 36'(MAG_SAT))
			t = 36'(MAG_SAT);
		num_mag = t[31:0];
	endfunction

	// Advance the predicted parser by one byte; returns 1 when a reading comes out
	function automatic bit predict_reading(input logic [7:0] c, output res_t r);
		bit          is_digit;
		logic [7:0]  d;
		logic [41:0] mag;
		logic [9:0]  scale;
		r = NO_RES;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = is_digit ? c - CH_ZERO : 8'd0;

		// idle: only '$' opens a frame
		if (frame_bytes == 0) begin
			if (c == CH_START) begin
				clear_frame();
				frame_bytes = 1;
			end
			return 1'b0;
		end

		// byte after CR: LF completes the frame, anything else drops it
		if (cr_pending) begin
			if (c == CH_LF) begin
				if (!m_found) begin
					r.status = STAT_NO_M;
				end else if (!comma_found) begin
					r.status = STAT_NO_COMMA;
				end else if (num_phase == PH_INT || num_phase == PH_FRAC ||
						num_phase == PH_DONE) begin
					case (frac_kept)
						2'd0: scale = 10'd1000;
						2'd1: scale = 10'd100;
						2'd2: scale = 10'd10;
						default: scale = 10'd1;
					endcase
					mag = 42'(num_mag) * 42'(scale);
					if (mag > 42'(MAG_SAT))
						mag = 42'(MAG_SAT);
					if (num_neg) begin
						r.milli = 32'd0 - mag[31:0];
					end else begin
						if (mag > 42'(POS_MAX))
							mag = 42'(POS_MAX);
						r.milli = mag[31:0];
					end
					r.ok     = 1'b1;
					r.status = STAT_OK;
				end else begin
					r.status = STAT_BAD_NUM;
				end
				clear_frame();
				return 1'b1;
			end
			clear_frame();
			return 1'b0;
		end

		if (c == CH_CR) begin
			cr_pending = 1'b1;
			return 1'b0;
		end

		// text bytes up to NUL or the first 'm'
		if (!text_done && !m_found) begin
			if (c == CH_NUL) begin
				text_done = 1'b1;
			end else if (c == CH_M) begin
				m_found = 1'b1;
			end else if (c == CH_COMMA) begin
				comma_found = 1'b1;
				clear_field();
			end else if (comma_found && !(num_phase == PH_LEAD && c == CH_SP)) begin
				if (num_phase == PH_LEAD)
					num_phase = PH_WS;
				case (num_phase)
					PH_WS: begin
						if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
							// white space keeps being skipped
						end else if (c == CH_PLUS || c == CH_MINUS) begin
							num_neg   = (c == CH_MINUS);
							num_phase = PH_SIGN;
						end else if (is_digit) begin
							push_digit(d);
							num_phase = PH_INT;
						end else if (c == CH_DOT) begin
							num_phase = PH_DOT;
						end else begin
							num_phase = PH_FAIL;
						end
					end
					PH_SIGN: begin
						if (is_digit) begin
							push_digit(d);
							num_phase = PH_INT;
						end else if (c == CH_DOT) begin
							num_phase = PH_DOT;
						end else begin
							num_phase = PH_FAIL;
						end
					end
					PH_INT: begin
						if (is_digit)
							push_digit(d);
						else if (c == CH_DOT)
							num_phase = PH_FRAC;
						else
							num_phase = PH_DONE;
					end
					PH_DOT, PH_FRAC: begin
						if (is_digit) begin
							if (frac_kept < 2'd3) begin
								push_digit(d);
								frac_kept = frac_kept + 2'd1;
							end
							num_phase = PH_FRAC;
						end else begin
							num_phase = (num_phase == PH_DOT) ? PH_FAIL : PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// frame length limit
		frame_bytes++;
		if (frame_bytes > FRAME_LEN - 1)
			clear_frame();
		return 1'b0;
	endfunction

	// Offer one byte, wait for its transfer, then predict
	task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
		res_t pred;
		bit   got;
		while ($urandom_range(0, 99) < send_idle_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
		got = predict_reading(b, pred);
		if (typed)
			expected_readings.push_back(want);
		else if (got)
			expected_readings.push_back(pred);
	endtask

	// Printable text byte that is neither 'm' nor a comma
	function automatic logic [7:0] rand_text_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h20, 8'h7E));
		while (c == CH_M || c == CH_COMMA);
		return c;
	endfunction

	// Build one random frame (or a burst of noise) into frame_buf
	task automatic build_frame(output bit is_noise);
		int kind;
		int n;
		int target;
		int sel;
		kind = $urandom_range(0, 99);
		frame_buf.delete();
		is_noise = (kind < 8);
		if (is_noise) begin
			repeat ($urandom_range(1, 8))
				frame_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end

		frame_buf.push_back(CH_START);
		// sentence head with some commas, none when the comma is to be missing
		repeat ($urandom_range(0, 6)) begin
			if (kind >= 12 && $urandom_range(0, 3) == 0)
				frame_buf.push_back(CH_COMMA);
			else
				frame_buf.push_back(rand_text_char());
		end
		if (kind >= 12)
			frame_buf.push_back(CH_COMMA);

		// numeric field
		repeat ($urandom_range(0, 2))
			frame_buf.push_back(CH_SP);
		if ($urandom_range(0, 7) == 0)
			frame_buf.push_back(8'($urandom_range(CH_TAB, 8'h0C)));
		if ($urandom_range(0, 9) != 0) begin
			sel = $urandom_range(0, 2);
			if (sel == 1)
				frame_buf.push_back(CH_PLUS);
			else if (sel == 2)
				frame_buf.push_back(CH_MINUS);
			sel = $urandom_range(0, 9);
			n = (sel == 0) ? 0 : (sel < 7) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			repeat (n)
				frame_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 1) == 1) begin
				frame_buf.push_back(CH_DOT);
				repeat ($urandom_range(0, 5))
					frame_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			sel = $urandom_range(0, 7);
			if (sel == 0) begin
				frame_buf.push_back(8'h65);
				frame_buf.push_back(8'h35);
			end else if (sel == 1) begin
				frame_buf.push_back(rand_text_char());
			end else if (sel == 2) begin
				frame_buf.push_back(CH_SP);
			end
		end

		if (kind < 12 || kind >= 16)
			frame_buf.push_back(CH_M);
		repeat ($urandom_range(0, 4))
			frame_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));

		// a NUL somewhere in the text
		if (kind >= 16 && kind < 22)
			frame_buf.insert($urandom_range(1, frame_buf.size() - 1), CH_NUL);

		// frames around the length limit
		if (kind >= 22 && kind < 28) begin
			target = $urandom_range(FRAME_LEN - 6, FRAME_LEN + 4);
			while (frame_buf.size() < target)
				frame_buf.push_back(rand_text_char());
		end

		frame_buf.push_back(CH_CR);
		if (kind >= 28 && kind < 34) begin
			do
				sel = $urandom_range(0, 255);
			while (sel == CH_LF);
			frame_buf.push_back(8'(sel));
		end else begin
			frame_buf.push_back(CH_LF);
		end
	endtask

	// Output side pacing, with one long hold-off on request
	always @(posedge clk) begin : recv_pacing
		int hold_left;
		int hold_seen;
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
		end
	end

	// Compare each output transfer with the oldest expected reading
	always @(posedge clk) begin : reading_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected reading: ok=%0b milli=%0d status=%0d",
					m_tdata[0], $signed(m_tdata[32:1]), m_tdata[34:33]);
				error_count++;
			end else begin
				want = expected_readings.pop_front();
				results_checked++;
				if (m_tdata[0] !== want.ok) begin
					$error("value_ok: expected %0b, got %0b", want.ok, m_tdata[0]);
					error_count++;
				end
				if (m_tdata[32:1] !== want.milli) begin
					$error("power_milli: expected %0d, got %0d", want.milli,
						$signed(m_tdata[32:1]));
					error_count++;
				end
				if (m_tdata[34:33] !== want.status) begin
					$error("status_code: expected %0d, got %0d", want.status,
						m_tdata[34:33]);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("power_meter_sentence_parser_top verification failed");
		$finish;
	end

	// Main sequence
	initial begin : stimulus
		bit noise;
		int counted;
		idle_mode = 0;
		hold_req = 0;
		error_count = 0;
		bytes_sent = 0;
		results_checked = 0;
		clear_frame();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_ROWS; i++)
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

		// random frames in three pacing phases; the first opens with a long output stall
		for (int ph = 0; ph < 3; ph++) begin
			idle_mode = ph;
			if (ph == 0)
				hold_req++;
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				build_frame(noise);
				foreach (frame_buf[i])
					send_byte(frame_buf[i], 1'b0, NO_RES);
				if (!noise)
					counted += frame_buf.size();
			end
		end
		s_tvalid <= 1'b0;

		// drain
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d bytes and %0d checked readings over three pacing phases,",
			bytes_sent, results_checked);
		$display("including a %0d-cycle output stall with the input still offered.",
			HOLD_CYCLES);
		if (error_count == 0)
			$display("power_meter_sentence_parser_top verification clean");
		else
			$display("power_meter_sentence_parser_top verification failed");
		$finish;
	end

endmodule
